@@ rtl/core/fra_pkg.sv @@
package fra_pkg;

  // Width of each input field
  localparam int IN_WIDTH  = 16;
  // Working width: full sum of two products, capped at a 64-bit wrap
  localparam int WORK_W    = (2 * IN_WIDTH + 1 > 64) ? 64 : 2 * IN_WIDTH + 1;
  localparam int NUM_SUM_W = 33;
  localparam int DEN_SUM_W = 32;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] num_a;
    logic signed [IN_WIDTH-1:0] den_a;
    logic signed [IN_WIDTH-1:0] num_b;
    logic signed [IN_WIDTH-1:0] den_b;
  } in_item_t;

  typedef struct packed {
    logic signed [NUM_SUM_W-1:0] num_sum;
    logic signed [DEN_SUM_W-1:0] den_sum;
    logic                        zero_factor;
  } out_item_t;

endpackage

@@ rtl/core/fraction_add_reduce_top.sv @@
// Adds two signed fractions num_a/den_a + num_b/den_b and reduces the result
// by a truncating Euclid factor, giving num_sum/den_sum.
// Input: present an item on in_item and raise start; it is taken at the edge
// where start is high and busy is low. busy stays high until the result goes.
// Output: out_valid is high for exactly one cycle with the result on
// out_item; the receiver must take it then, there is no back-pressure.
// When both sum and product are zero the result is 0/0 with zero_factor set.
// Flow: the three bit-serial products come first, then each Euclid step
// runs in the shared radix-2 divider, which also forms the two final
// quotients. With 16-bit fields WORK_W is 33. One item is in flight at a
// time; the next may start in the cycle out_valid is high.
// Reset (synchronous, rst_n low) drops any item in flight and returns to idle.
module fraction_add_reduce_top
  import fra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_GCD,
    ST_QN,
    ST_QD
  } state_t;

  state_t            state_r, state_nxt;
  logic [WORK_W-1:0] num_r, num_nxt;
  logic [WORK_W-1:0] den_r, den_nxt;
  logic [WORK_W-1:0] x_r, x_nxt;
  logic [WORK_W-1:0] y_r, y_nxt;
  logic [WORK_W-1:0] qn_r, qn_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              mul_go;
  logic [WORK_W-1:0] p_ad, p_cb, p_bd;
  logic [2:0]        mul_dones;
  logic              mul_done;
  logic [WORK_W-1:0] sum;

  logic              div_go;
  logic [WORK_W-1:0] div_dvd, div_dvs;
  logic [WORK_W-1:0] div_quo, div_rem;
  logic              div_done;

  assign busy   = (state_r != ST_IDLE);
  assign mul_go = start && !busy;

  fra_mul u_mul_ad (
    .clk, .rst_n, .go(mul_go),
    .mcand(in_item.num_a), .mplier(in_item.den_b),
    .prod(p_ad), .done(mul_dones[0])
  );

  fra_mul u_mul_cb (
    .clk, .rst_n, .go(mul_go),
    .mcand(in_item.num_b), .mplier(in_item.den_a),
    .prod(p_cb), .done(mul_dones[1])
  );

  fra_mul u_mul_bd (
    .clk, .rst_n, .go(mul_go),
    .mcand(in_item.den_a), .mplier(in_item.den_b),
    .prod(p_bd), .done(mul_dones[2])
  );

  assign mul_done = &mul_dones;
  assign sum      = p_ad + p_cb;

  fra_div u_div (
    .clk, .rst_n, .go(div_go),
    .dividend(div_dvd), .divisor(div_dvs),
    .quo(div_quo), .rem(div_rem), .done(div_done)
  );

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    qn_nxt        = qn_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    div_go        = 1'b0;
    div_dvd       = y_r;
    div_dvs       = x_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          num_nxt   = sum;
          den_nxt   = p_bd;
          x_nxt     = sum;
          y_nxt     = p_bd;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (x_r != '0) begin
          div_go    = 1'b1;
          state_nxt = ST_GCD;
        end else if (y_r == '0) begin
          // factor is zero: report 0/0 with the flag
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.zero_factor = 1'b1;
          state_nxt           = ST_IDLE;
        end else begin
          div_go    = 1'b1;
          div_dvd   = num_r;
          div_dvs   = y_r;
          state_nxt = ST_QN;
        end
      end
      ST_GCD: begin
        if (div_done) begin
          y_nxt     = x_r;
          x_nxt     = div_rem;
          state_nxt = ST_CHK;
        end
      end
      ST_QN: begin
        if (div_done) begin
          qn_nxt    = div_quo;
          div_go    = 1'b1;
          div_dvd   = den_r;
          div_dvs   = y_r;
          state_nxt = ST_QD;
        end
      end
      ST_QD: begin
        if (div_done) begin
          out_valid_nxt       = 1'b1;
          out_nxt.num_sum     = NUM_SUM_W'(signed'(qn_r));
          out_nxt.den_sum     = DEN_SUM_W'(signed'(div_quo));
          out_nxt.zero_factor = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    qn_r  <= qn_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in flight");

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.zero_factor |->
      (out_item.num_sum == '0 && out_item.den_sum == '0))
    else $error("zero factor result carries non-zero fields");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("products finished outside the multiply phase");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_GCD || state_r == ST_QN || state_r == ST_QD))
    else $error("divider finished outside a divide phase");

endmodule

@@ rtl/core/fra_mul.sv @@
module fra_mul
  import fra_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic signed [IN_WIDTH-1:0] mcand,
  input  logic signed [IN_WIDTH-1:0] mplier,
  output logic [WORK_W-1:0]          prod,
  output logic                       done
);

  localparam int CNT_W = $clog2(IN_WIDTH);

  logic [WORK_W-1:0]   acc_r, acc_nxt;
  logic [WORK_W-1:0]   mcand_r, mcand_nxt;
  logic [IN_WIDTH-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [WORK_W-1:0]   addend;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    done_nxt   = 1'b0;
    addend     = mplier_r[0] ? mcand_r : '0;
    if (go) begin
      acc_nxt    = '0;
      mcand_nxt  = WORK_W'(mcand);
      mplier_nxt = mplier;
      cnt_nxt    = CNT_W'(IN_WIDTH - 1);
      run_nxt    = 1'b1;
    end else if (run_r) begin
      // the multiplier's sign bit carries negative weight
      acc_nxt    = (cnt_r == '0) ? acc_r - addend : acc_r + addend;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

@@ rtl/core/fra_div.sv @@
module fra_div
  import fra_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [WORK_W-1:0] dividend,
  input  logic [WORK_W-1:0] divisor,
  output logic [WORK_W-1:0] quo,
  output logic [WORK_W-1:0] rem,
  output logic              done
);

  localparam int CNT_W = $clog2(WORK_W);

  logic [WORK_W-1:0] q_r, q_nxt;
  logic [WORK_W-1:0] r_r, r_nxt;
  logic [WORK_W-1:0] dvs_r, dvs_nxt;
  logic              qneg_r, qneg_nxt;
  logic              rneg_r, rneg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [WORK_W:0]   trial;
  logic [WORK_W:0]   diff;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    dvs_nxt  = dvs_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {r_r, q_r[WORK_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (go) begin
      // work on magnitudes, restore signs at the output
      q_nxt    = dividend[WORK_W-1] ? -dividend : dividend;
      dvs_nxt  = divisor[WORK_W-1] ? -divisor : divisor;
      r_nxt    = '0;
      qneg_nxt = dividend[WORK_W-1] ^ divisor[WORK_W-1];
      rneg_nxt = dividend[WORK_W-1];
      cnt_nxt  = CNT_W'(WORK_W - 1);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (!diff[WORK_W]) begin
        r_nxt = diff[WORK_W-1:0];
        q_nxt = {q_r[WORK_W-2:0], 1'b1};
      end else begin
        r_nxt = trial[WORK_W-1:0];
        q_nxt = {q_r[WORK_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    dvs_r  <= dvs_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign quo  = qneg_r ? -q_r : q_r;
  assign rem  = rneg_r ? -r_r : r_r;
  assign done = done_r;

endmodule

@@ tb/tb_fraction_add_reduce_top.sv @@
module tb_fraction_add_reduce_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fra_pkg::*;

  localparam longint FIELD_MAX = (64'sd1 <<< (IN_WIDTH - 1)) - 1;
  localparam longint FIELD_MIN = -(64'sd1 <<< (IN_WIDTH - 1));
  localparam int     SETTLE_CYCLES = 40;
  localparam int     MAX_GAP = 40;

  typedef struct packed {
    in_item_t  operands;
    out_item_t sum;
  } pending_sum_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  pending_sum_t pending_sums[$];
  pending_sum_t oldest_sum;
  int mismatches = 0;
  int items_sent = 0;
  int zero_factor_items = 0;
  int negative_factor_items = 0;
  int sender_idle_pct = 0;

  fraction_add_reduce_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sum the two fractions, find the truncating Euclid factor and divide it out
  function automatic out_item_t reduce_sum(input in_item_t it, output bit neg_factor);
    longint a, b, c, d, num, den, x, y, r;
    out_item_t res;
    a = it.num_a;
    b = it.den_a;
    c = it.num_b;
    d = it.den_b;
    num = a * d + c * b;
    den = b * d;
    x = num;
    y = den;
    while (x != 0) begin
      r = (x == -1) ? 64'sd0 : y % x;
      y = x;
      x = r;
    end
    neg_factor = (y < 0);
    res = '0;
    if (y == 0) begin
      res.zero_factor = 1'b1;
    end else begin
      res.num_sum = NUM_SUM_W'((y == -1) ? -num : num / y);
      res.den_sum = DEN_SUM_W'((y == -1) ? -den : den / y);
    end
    return res;
  endfunction

  function automatic in_item_t pack_item(input longint a, input longint b,
                                         input longint c, input longint d);
    in_item_t it;
    it.num_a = IN_WIDTH'(a);
    it.den_a = IN_WIDTH'(b);
    it.num_b = IN_WIDTH'(c);
    it.den_b = IN_WIDTH'(d);
    return it;
  endfunction

  function automatic longint small_value();
    return longint'($urandom_range(40)) - 20;
  endfunction

  function automatic longint mixed_value();
    case ($urandom_range(3))
      0: return longint'($urandom);
      1: return small_value();
      2: begin
        case ($urandom_range(4))
          0: return FIELD_MIN;
          1: return FIELD_MAX;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
      default: return 0;
    endcase
  endfunction

  function automatic in_item_t random_fraction_pair();
    longint v[4];
    longint k;
    int shape;
    shape = $urandom_range(3);
    k = $urandom_range(181, 1);
    foreach (v[i]) begin
      case (shape)
        0: v[i] = longint'($urandom);
        1: v[i] = small_value();
        // shared factor, so the reduction has real work to do
        2: v[i] = k * (longint'($urandom_range(362)) - 181);
        default: v[i] = mixed_value();
      endcase
    end
    return pack_item(v[0], v[1], v[2], v[3]);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Leaves start high on return; any caller that waits must lower it first
  task automatic send_item(input in_item_t it);
    pending_sum_t entry;
    bit neg;
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
      gap++;
    if (gap != 0) begin
      start <= 1'b0;
      // count the gap from the point where the block is ready again
      @(posedge clk);
      while (busy !== 1'b0) @(posedge clk);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    entry.operands = it;
    entry.sum = reduce_sum(it, neg);
    pending_sums.push_back(entry);
    items_sent++;
    if (entry.sum.zero_factor)
      zero_factor_items++;
    if (neg)
      negative_factor_items++;
  endtask

  task automatic await_drained();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        oldest_sum = pending_sums.pop_front();
        if (out_item.num_sum !== oldest_sum.sum.num_sum)
          report_mismatch($sformatf("%0d/%0d + %0d/%0d: num_sum %0d, want %0d",
            oldest_sum.operands.num_a, oldest_sum.operands.den_a,
            oldest_sum.operands.num_b, oldest_sum.operands.den_b,
            out_item.num_sum, oldest_sum.sum.num_sum));
        if (out_item.den_sum !== oldest_sum.sum.den_sum)
          report_mismatch($sformatf("%0d/%0d + %0d/%0d: den_sum %0d, want %0d",
            oldest_sum.operands.num_a, oldest_sum.operands.den_a,
            oldest_sum.operands.num_b, oldest_sum.operands.den_b,
            out_item.den_sum, oldest_sum.sum.den_sum));
        if (out_item.zero_factor !== oldest_sum.sum.zero_factor)
          report_mismatch($sformatf("%0d/%0d + %0d/%0d: zero_factor %b, want %b",
            oldest_sum.operands.num_a, oldest_sum.operands.den_a,
            oldest_sum.operands.num_b, oldest_sum.operands.den_b,
            out_item.zero_factor, oldest_sum.sum.zero_factor));
      end
    end
  end

  task automatic test_special_cases();
    sender_idle_pct = 0;
    send_item(pack_item(1, 2, 1, 3));
    send_item(pack_item(0, 1, 0, 1));
    // sum and product both zero: 0/0 with the flag
    send_item(pack_item(0, 0, 0, 0));
    send_item(pack_item(5, 0, 3, 0));
    send_item(pack_item(7, 0, 0, 0));
    // one denominator zero: reduces to 1/0
    send_item(pack_item(1, 0, 1, 1));
    send_item(pack_item(0, 3, 4, 0));
    // factor of minus one
    send_item(pack_item(-1, 1, 0, 1));
    // negative factor flips the signs
    send_item(pack_item(-6, 4, 0, 1));
    send_item(pack_item(-3, -4, -5, -6));
    send_item(pack_item(1, 2, -1, 2));
    send_item(pack_item(0, 5, 0, -7));
    send_item(pack_item(-1, -1, -1, -1));
  endtask

  task automatic test_field_extremes();
    sender_idle_pct = 0;
    send_item(pack_item(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
    send_item(pack_item(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
    send_item(pack_item(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX));
    send_item(pack_item(FIELD_MIN, 1, FIELD_MIN, 1));
    send_item(pack_item(FIELD_MAX, 1, FIELD_MAX, 1));
    send_item(pack_item(1, FIELD_MIN, 1, FIELD_MAX));
    send_item(pack_item(12345, FIELD_MIN, FIELD_MIN, 12345));
    send_item(pack_item(FIELD_MIN, -1, FIELD_MAX, -1));
  endtask

  task automatic test_random_items(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_item(random_fraction_pair());
  endtask

  task automatic test_pause_until_drained();
    sender_idle_pct = 0;
    repeat (6) begin
      send_item(random_fraction_pair());
      await_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_field_extremes();
    test_random_items(120, 0);
    test_pause_until_drained();
    test_random_items(120, 81);
    test_random_items(120, 27);
    await_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d fraction pairs: %0d with zero factor, %0d with negative factor,",
             items_sent, zero_factor_items, negative_factor_items);
    $display("sender idling at none, 27 and 81 percent, plus pauses until drained.");
    if (mismatches == 0) begin
      $display("tb_fraction_add_reduce_top passed");
    end else begin
      $display("tb_fraction_add_reduce_top failed");
    end
    $finish;
  end

  initial begin
    #7_000_000;
    $display("tb_fraction_add_reduce_top failed");
    $finish;
  end

endmodule
